// ===== sv/ffra_pkg.sv =====
// Shared constants, codes and types of the first-fit region allocator.
`default_nettype none
package ffra_pkg;
  localparam int HOLE_ENTRIES_DEF   = 64;
  localparam int UNIT_ADDR_BITS_DEF = 24;

  localparam int              CAP_W     = 25;
  localparam logic [CAP_W-1:0] CAP_RESET = 25'd1048576;
  localparam int              PADDR_W   = 3;
  localparam logic [PADDR_W-1:0] CAP_ADDR = 3'd0;

  localparam int             STAT_W      = 2;
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  localparam int           OP_W          = 3;
  localparam logic [OP_W-1:0] OP_HOLD       = 3'd0;
  localparam logic [OP_W-1:0] OP_TRIM       = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP       = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd3;
  localparam logic [OP_W-1:0] OP_MERGE_PREV = 3'd4;
  localparam logic [OP_W-1:0] OP_MERGE_BOTH = 3'd5;
  localparam logic [OP_W-1:0] OP_MERGE_NEXT = 3'd6;

  typedef struct packed {
    logic fit;
    logic exact;
    logic lt;
    logic touch_after;
    logic touch_before;
  } cell_flags_t;

  typedef struct packed {
    logic            cmp_en;
    logic [OP_W-1:0] op;
  } cell_cmd_t;
endpackage
`default_nettype wire

// ===== sv/ffra_cell.sv =====
// One hole slot of the sorted hole chain: compare flags and neighbor shifts.
`default_nettype none
module ffra_cell import ffra_pkg::*; #(
  parameter int UNIT_ADDR_BITS = UNIT_ADDR_BITS_DEF,
  parameter int POS_W          = 7,
  parameter int IDX            = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cell_cmd_t                 cmd_i,
  input  wire logic [POS_W-1:0]          target_i,
  input  wire logic [UNIT_ADDR_BITS-1:0] req_start_i,
  input  wire logic [UNIT_ADDR_BITS:0]   req_len_i,
  input  wire logic [UNIT_ADDR_BITS-1:0] left_start_i,
  input  wire logic [UNIT_ADDR_BITS:0]   left_len_i,
  input  wire logic                      left_valid_i,
  input  wire logic [UNIT_ADDR_BITS-1:0] right_start_i,
  input  wire logic [UNIT_ADDR_BITS:0]   right_len_i,
  input  wire logic                      right_valid_i,
  output logic [UNIT_ADDR_BITS-1:0]      start_o,
  output logic [UNIT_ADDR_BITS:0]        len_o,
  output logic                           valid_o,
  output cell_flags_t                    flags_o
);
  localparam int LW = UNIT_ADDR_BITS + 1;
  localparam int XW = UNIT_ADDR_BITS + 3;

  logic [UNIT_ADDR_BITS-1:0] start_q, start_d;
  logic [LW-1:0]             len_q, len_d;
  logic                      valid_q, valid_d;
  cell_flags_t               flags_q, flags_d;

  logic [XW-1:0] end_x, req_end_x, sum_one, sum_both;
  logic [LW-1:0] sat_one, sat_both, sat_next;
  logic          here, above;

  assign end_x     = XW'(start_q) + XW'(len_q);
  assign req_end_x = XW'(req_start_i) + XW'(req_len_i);
  assign sum_one   = XW'(len_q) + XW'(req_len_i);
  assign sum_both  = sum_one + XW'(right_len_i);
  // saturate merged lengths at the length field maximum
  assign sat_one   = (|sum_one[XW-1:LW])  ? '1 : sum_one[LW-1:0];
  assign sat_both  = (|sum_both[XW-1:LW]) ? '1 : sum_both[LW-1:0];
  assign sat_next  = sat_one;
  assign here      = (target_i == POS_W'(IDX));
  assign above     = (target_i <  POS_W'(IDX));

  always_comb begin
    flags_d.fit          = valid_q && (len_q >= req_len_i);
    flags_d.exact        = valid_q && (len_q == req_len_i);
    flags_d.lt           = valid_q && (start_q < req_start_i);
    flags_d.touch_after  = valid_q && (end_x == XW'(req_start_i));
    flags_d.touch_before = valid_q && (req_end_x == XW'(start_q));
  end

  always_comb begin
    start_d = start_q;
    len_d   = len_q;
    valid_d = valid_q;
    case (cmd_i.op)
      OP_TRIM: begin
        if (here) begin
          start_d = start_q + req_len_i[UNIT_ADDR_BITS-1:0];
          len_d   = len_q - req_len_i;
        end
      end
      OP_DROP: begin
        if (here || above) begin
          start_d = right_start_i;
          len_d   = right_len_i;
          valid_d = right_valid_i;
        end
      end
      OP_INSERT: begin
        if (here) begin
          start_d = req_start_i;
          len_d   = req_len_i;
          valid_d = 1'b1;
        end else if (above) begin
          start_d = left_start_i;
          len_d   = left_len_i;
          valid_d = left_valid_i;
        end
      end
      OP_MERGE_PREV: begin
        if (here) len_d = sat_one;
      end
      OP_MERGE_BOTH: begin
        if (here) begin
          len_d = sat_both;
        end else if (above) begin
          start_d = right_start_i;
          len_d   = right_len_i;
          valid_d = right_valid_i;
        end
      end
      OP_MERGE_NEXT: begin
        if (here) begin
          start_d = req_start_i;
          len_d   = sat_next;
        end
      end
      default: begin
        start_d = start_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flags_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.cmp_en) flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
  end

  assign start_o = start_q;
  assign len_o   = len_q;
  assign valid_o = valid_q;
  assign flags_o = flags_q;
endmodule
`default_nettype wire

// ===== sv/first_fit_region_allocator.sv =====
// From acceptance to result valid an item passes compare, decide and update states.
// The hole chain handles one item at a time; update waits while the output stalls.
// Compare reaches all cells at once; update shifts the chain by at most one slot.
// A result may wait at the output register while the next item is accepted.
// Reset clears the hole valid bits, hole count and high-water mark; capacity
// resets to 1048576 units. No clearing pass is needed.
`default_nettype none
module first_fit_region_allocator import ffra_pkg::*; #(
  parameter int HOLE_ENTRIES   = HOLE_ENTRIES_DEF,
  parameter int UNIT_ADDR_BITS = UNIT_ADDR_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      mode_i,
  input  wire logic [UNIT_ADDR_BITS-1:0] range_start_i,
  input  wire logic [UNIT_ADDR_BITS:0]   range_length_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [STAT_W-1:0]              status_o,
  output logic [UNIT_ADDR_BITS-1:0]      granted_start_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [PADDR_W-1:0]        paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  localparam int N     = HOLE_ENTRIES;
  localparam int A     = UNIT_ADDR_BITS;
  localparam int LW    = A + 1;
  localparam int POS_W = $clog2(N + 1);
  localparam int IW    = $clog2(N);
  localparam int CW    = (CAP_W > A + 2) ? CAP_W : A + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CAP_W-1:0]  capacity_q;
  logic [LW-1:0]     high_water_q, high_water_d;
  logic [POS_W-1:0]  count_q, count_d;
  logic              mode_q;
  logic [A-1:0]      rs_q;
  logic [LW-1:0]     rl_q;
  logic [OP_W-1:0]   op_q, op_d;
  logic [POS_W-1:0]  target_q, target_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [A-1:0]      grant_q, grant_d;
  logic              out_valid_q;
  logic [STAT_W-1:0] out_stat_q;
  logic [A-1:0]      out_grant_q;

  logic [A-1:0]   c_start [N];
  logic [LW-1:0]  c_len   [N];
  logic           c_valid [N];
  cell_flags_t    c_flags [N];
  cell_cmd_t      cmd;

  logic [N-1:0]   fit_vec, exact_vec, lt_vec;
  logic [N:0]     prev_ext, next_ext;
  logic           fit_any, join_prev, join_next, out_free, upd_fire;
  logic [IW-1:0]  fit_idx;
  logic [POS_W-1:0] pos;
  logic [CW-1:0]  span, cap_eff, bump_sum;

  assign pready   = 1'b1;
  assign prdata   = (paddr == CAP_ADDR) ? 32'(capacity_q) : 32'd0;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign upd_fire = (state_q == S_UPD) && out_free;

  always_comb begin
    cmd.cmp_en = (state_q == S_CMP);
    cmd.op     = upd_fire ? op_q : OP_HOLD;
  end

  for (genvar k = 0; k < N; k++) begin : g_chain
    logic [A-1:0]  l_start, r_start;
    logic [LW-1:0] l_len, r_len;
    logic          l_valid, r_valid;
    if (k == 0) begin : g_first
      assign l_start = '0;
      assign l_len   = '0;
      assign l_valid = 1'b0;
    end else begin : g_mid_l
      assign l_start = c_start[k-1];
      assign l_len   = c_len[k-1];
      assign l_valid = c_valid[k-1];
    end
    if (k == N - 1) begin : g_last
      assign r_start = '0;
      assign r_len   = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_start = c_start[k+1];
      assign r_len   = c_len[k+1];
      assign r_valid = c_valid[k+1];
    end
    ffra_cell #(
      .UNIT_ADDR_BITS(A),
      .POS_W(POS_W),
      .IDX(k)
    ) u_cell (
      .clk_i, .rst_ni,
      .cmd_i(cmd), .target_i(target_q),
      .req_start_i(rs_q), .req_len_i(rl_q),
      .left_start_i(l_start), .left_len_i(l_len), .left_valid_i(l_valid),
      .right_start_i(r_start), .right_len_i(r_len), .right_valid_i(r_valid),
      .start_o(c_start[k]), .len_o(c_len[k]), .valid_o(c_valid[k]),
      .flags_o(c_flags[k])
    );
    assign fit_vec[k]   = c_flags[k].fit;
    assign exact_vec[k] = c_flags[k].exact;
    assign lt_vec[k]    = c_flags[k].lt;
    assign prev_ext[k+1] = c_flags[k].touch_after;
    assign next_ext[k]   = c_flags[k].touch_before;
  end
  assign prev_ext[0] = 1'b0;
  assign next_ext[N] = 1'b0;

  // first fitting hole and sorted insert position
  always_comb begin
    fit_any = 1'b0;
    fit_idx = '0;
    pos     = POS_W'(N);
    for (int k = N - 1; k >= 0; k--) begin
      if (fit_vec[k]) begin
        fit_any = 1'b1;
        fit_idx = IW'(k);
      end
      if (!lt_vec[k]) pos = POS_W'(k);
    end
  end

  assign join_prev = prev_ext[pos];
  assign join_next = next_ext[pos];
  assign span      = CW'(1) << A;
  assign cap_eff   = (CW'(capacity_q) < span) ? CW'(capacity_q) : span;
  assign bump_sum  = CW'(high_water_q) + CW'(rl_q);

  always_comb begin
    op_d         = OP_HOLD;
    target_d     = '0;
    stat_d       = STAT_OK;
    grant_d      = '0;
    high_water_d = high_water_q;
    count_d      = count_q;
    if (!mode_q) begin
      if (fit_any) begin
        grant_d  = c_start[fit_idx];
        target_d = POS_W'(fit_idx);
        if (exact_vec[fit_idx]) begin
          op_d    = OP_DROP;
          count_d = count_q - 1'b1;
        end else begin
          op_d = OP_TRIM;
        end
      end else if (bump_sum <= cap_eff) begin
        grant_d      = high_water_q[A-1:0];
        high_water_d = bump_sum[LW-1:0];
      end else begin
        stat_d = STAT_FULL;
      end
    end else if (rl_q != '0) begin
      if (join_prev) begin
        target_d = pos - 1'b1;
        if (join_next) begin
          op_d    = OP_MERGE_BOTH;
          count_d = count_q - 1'b1;
        end else begin
          op_d = OP_MERGE_PREV;
        end
      end else if (join_next) begin
        op_d     = OP_MERGE_NEXT;
        target_d = pos;
      end else if (count_q >= POS_W'(N)) begin
        stat_d = STAT_OVERFLOW;
      end else begin
        op_d     = OP_INSERT;
        target_d = pos;
        count_d  = count_q + 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CMP;
      S_CMP:   state_d = S_DEC;
      S_DEC:   state_d = S_UPD;
      S_UPD:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      capacity_q   <= CAP_RESET;
      high_water_q <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && pready && (paddr == CAP_ADDR)) begin
        capacity_q <= pwdata[CAP_W-1:0];
      end
      if (state_q == S_DEC) begin
        high_water_q <= high_water_d;
        count_q      <= count_d;
      end
      if (upd_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      rs_q   <= range_start_i;
      rl_q   <= range_length_i;
    end
    if (state_q == S_DEC) begin
      op_q     <= op_d;
      target_q <= target_d;
      stat_q   <= stat_d;
      grant_q  <= grant_d;
    end
    if (upd_fire) begin
      out_stat_q  <= stat_q;
      out_grant_q <= grant_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_stat_q;
  assign granted_start_o = out_grant_q;
endmodule
`default_nettype wire

// ===== sv/ffra_checker.sv =====
// Port-level checks of the first-fit region allocator, bound to the top level.
`default_nettype none
module ffra_checker import ffra_pkg::*; #(
  parameter int UNIT_ADDR_BITS = UNIT_ADDR_BITS_DEF
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [STAT_W-1:0]         status_o,
  input wire logic [UNIT_ADDR_BITS-1:0] granted_start_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_start_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_OK || status_o == STAT_FULL
      || status_o == STAT_OVERFLOW))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> granted_start_o == '0)
    else $error("granted start nonzero on failed item");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("item accepted while previous item in work");
endmodule

bind first_fit_region_allocator ffra_checker #(
  .UNIT_ADDR_BITS(UNIT_ADDR_BITS)
) u_ffra_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
  .out_valid_o, .out_ready_i, .status_o, .granted_start_o
);
`default_nettype wire
